[rtl/sqllex_pkg.sv]
// Shared types and constants of the SQL token lexer.
`default_nettype none

package sqllex_pkg;

   localparam int OUT_POS_BITS   = 16;
   localparam int OUT_VALUE_BITS = 32;
   localparam int TYPE_BITS      = 3;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'd0,
      MODE_WORD   = 4'd1,
      MODE_NUMBER = 4'd2,
      MODE_STRING = 4'd3,
      MODE_STRQ   = 4'd4,
      MODE_DASH   = 4'd5,
      MODE_SLASH  = 4'd6,
      MODE_GT     = 4'd7,
      MODE_LT     = 4'd8,
      MODE_BANG   = 4'd9,
      MODE_LINE   = 4'd10,
      MODE_BLOCK  = 4'd11,
      MODE_BSTAR  = 4'd12
   } mode_type;

   typedef enum logic [TYPE_BITS-1:0] {
      TOK_EOF    = 3'd0,
      TOK_WORD   = 3'd1,
      TOK_NUMBER = 3'd2,
      TOK_STRING = 3'd3,
      TOK_DELIM  = 3'd4,
      TOK_ERROR  = 3'd5
   } tok_type_type;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_Z   = 8'h7A;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_Z    = 8'h5A;

   typedef struct packed {
      tok_type_type              token_type;
      logic [OUT_POS_BITS-1:0]   start_offset;
      logic [OUT_POS_BITS-1:0]   token_length;
      logic [OUT_VALUE_BITS-1:0] number_value;
      logic                      last;
   } result_type;

endpackage

`default_nettype wire

[rtl/sql_token_lexer_core.sv]
// Top level of the streaming SQL token lexer.
//
//   channel  direction  ports                                         transaction
//   req      in         req_ch, req_at_end                            one text byte or end
//   rsp      out        rsp_token_type, rsp_start_offset,             one token
//                       rsp_token_length, rsp_number_value, rsp_last
//
// One byte is taken per cycle while the queue has room; its tokens (zero, one or
// two) enter a four-entry queue in the same cycle and leave at one per cycle.
// The queue must have room for two tokens to take a byte, so a run of bytes that
// each give two tokens is limited by the single output port.
// Reset clears the lexer state and empties the queue; no clearing pass is needed.
// A stalled rsp side holds the queue head and backs up into req_ready.
`default_nettype none

module sql_token_lexer_core
   import sqllex_pkg::*;
#(
   parameter int POS_BITS   = 16,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [7:0]                req_ch,
   input  wire logic                      req_at_end,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [TYPE_BITS-1:0]           rsp_token_type,
   output logic [OUT_POS_BITS-1:0]        rsp_start_offset,
   output logic [OUT_POS_BITS-1:0]        rsp_token_length,
   output logic [OUT_VALUE_BITS-1:0]      rsp_number_value,
   output logic                           rsp_last
);

   mode_type              mode_ff, mode_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in, start_ff, start_in, len_ff, len_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [1:0]            result_count;
   result_type            result0, result1, head;
   logic [1:0]            push_count;
   logic                  queue_room;
   logic                  req_take;

   assign req_ready  = queue_room;
   assign req_take   = req_valid && req_ready;
   assign push_count = req_take ? result_count : 2'd0;

   sqllex_step #(
      .POS_BITS   (POS_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_step (
      .mode_ff      (mode_ff),
      .pos_ff       (pos_ff),
      .start_ff     (start_ff),
      .len_ff       (len_ff),
      .acc_ff       (acc_ff),
      .ch           (req_ch),
      .at_end       (req_at_end),
      .mode_in      (mode_in),
      .pos_in       (pos_in),
      .start_in     (start_in),
      .len_in       (len_in),
      .acc_in       (acc_in),
      .result_count (result_count),
      .result0      (result0),
      .result1      (result1)
   );

   sqllex_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data0 (result0),
      .push_data1 (result1),
      .pop        (rsp_ready),
      .has_room   (queue_room),
      .head_valid (rsp_valid),
      .head_data  (head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         acc_ff   <= '0;
      end else if (req_take) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         acc_ff   <= acc_in;
      end
   end

   assign rsp_token_type   = head.token_type;
   assign rsp_start_offset = head.start_offset;
   assign rsp_token_length = head.token_length;
   assign rsp_number_value = head.number_value;
   assign rsp_last         = head.last;

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_at_end || (req_ch == CH_NUL)))
         |=> ((mode_ff == MODE_IDLE) && (pos_ff == '0) && (acc_ff == '0)))
      else $error("end of text did not return the lexer to its reset state");

   a_end_pushes_eof: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_at_end) |-> (result_count != 2'd0))
      else $error("end of text produced no end-of-file token");

endmodule

`default_nettype wire

[rtl/sqllex_step.sv]
// Combinational next-state and token decode for one text byte.
`default_nettype none

module sqllex_step
   import sqllex_pkg::*;
#(
   parameter int POS_BITS   = 16,
   parameter int VALUE_BITS = 32
) (
   input  wire mode_type              mode_ff,
   input  wire logic [POS_BITS-1:0]   pos_ff,
   input  wire logic [POS_BITS-1:0]   start_ff,
   input  wire logic [POS_BITS-1:0]   len_ff,
   input  wire logic [VALUE_BITS-1:0] acc_ff,
   input  wire logic [7:0]            ch,
   input  wire logic                  at_end,
   output mode_type                   mode_in,
   output logic [POS_BITS-1:0]        pos_in,
   output logic [POS_BITS-1:0]        start_in,
   output logic [POS_BITS-1:0]        len_in,
   output logic [VALUE_BITS-1:0]      acc_in,
   output logic [1:0]                 result_count,
   output result_type                 result0,
   output result_type                 result1
);

   function automatic logic [POS_BITS-1:0] sat_add(logic [POS_BITS-1:0] x, logic [1:0] k);
      logic [POS_BITS:0] s;
      s = {1'b0, x} + (POS_BITS+1)'(k);
      return s[POS_BITS] ? '1 : s[POS_BITS-1:0];
   endfunction

   function automatic logic [OUT_POS_BITS-1:0] to_out_pos(logic [POS_BITS-1:0] x);
      logic [31:0] t;
      t = 32'(x);
      return t[OUT_POS_BITS-1:0];
   endfunction

   function automatic logic [OUT_VALUE_BITS-1:0] to_out_val(logic [VALUE_BITS-1:0] x);
      logic [63:0] t;
      t = 64'(x);
      return t[OUT_VALUE_BITS-1:0];
   endfunction

   logic is_end, is_space, is_digit, is_alpha, is_wordch, pair_hit;
   logic [POS_BITS-1:0]   pos_inc;
   logic [VALUE_BITS-1:0] digit_val, acc_next;

   // Outcome of starting a fresh token at the current byte.
   mode_type              b_mode;
   logic [POS_BITS-1:0]   b_start, b_len;
   logic [VALUE_BITS-1:0] b_acc;
   logic                  b_delim;

   logic                  use_begin;
   logic                  a_valid, b_valid;
   tok_type_type          a_type, b_type;
   logic [POS_BITS-1:0]   a_start, a_len, b_rstart, b_rlen;
   logic [VALUE_BITS-1:0] a_val;
   result_type            res_a, res_b;

   assign is_end    = at_end || (ch == CH_NUL);
   assign is_space  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
   assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_alpha  = ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z))
                   || ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
   assign is_wordch = is_alpha || is_digit || (ch == CH_UNDER);
   assign pair_hit  = (ch == CH_EQUAL) || ((mode_ff == MODE_LT) && (ch == CH_GT));
   assign pos_inc   = sat_add(pos_ff, 2'd1);
   assign digit_val = VALUE_BITS'(ch[3:0]);
   // Times ten as two shifted copies, wrapping at the accumulator width.
   assign acc_next  = (acc_ff << 3) + (acc_ff << 1) + digit_val;

   always_comb begin
      b_mode  = MODE_IDLE;
      b_start = pos_ff;
      b_len   = '0;
      b_acc   = '0;
      b_delim = 1'b0;
      if (is_space) begin
         b_mode = MODE_IDLE;
      end else if (is_alpha || (ch == CH_UNDER)) begin
         b_mode = MODE_WORD;
         b_len  = POS_BITS'(1);
      end else if (is_digit) begin
         b_mode = MODE_NUMBER;
         b_len  = POS_BITS'(1);
         b_acc  = digit_val;
      end else if (ch == CH_QUOTE) begin
         b_mode  = MODE_STRING;
         b_start = pos_inc;
      end else if (ch == CH_DASH) begin
         b_mode = MODE_DASH;
      end else if (ch == CH_SLASH) begin
         b_mode = MODE_SLASH;
      end else if (ch == CH_GT) begin
         b_mode = MODE_GT;
      end else if (ch == CH_LT) begin
         b_mode = MODE_LT;
      end else if (ch == CH_BANG) begin
         b_mode = MODE_BANG;
      end else begin
         b_delim = 1'b1;
      end
   end

   // Next mode.
   always_comb begin
      mode_in = mode_ff;
      if (is_end) begin
         mode_in = MODE_IDLE;
      end else begin
         unique case (mode_ff)
            MODE_WORD:   if (!is_wordch) mode_in = b_mode;
            MODE_NUMBER: if (!is_digit) mode_in = b_mode;
            MODE_STRING: if (ch == CH_QUOTE) mode_in = MODE_STRQ;
            MODE_STRQ:   mode_in = (ch == CH_QUOTE) ? MODE_STRING : b_mode;
            MODE_DASH:   mode_in = (ch == CH_DASH) ? MODE_LINE : b_mode;
            MODE_SLASH:  mode_in = (ch == CH_STAR) ? MODE_BLOCK : b_mode;
            MODE_GT, MODE_LT, MODE_BANG: mode_in = pair_hit ? MODE_IDLE : b_mode;
            MODE_LINE:   if (ch == CH_NEWLINE) mode_in = MODE_IDLE;
            MODE_BLOCK:  if (ch == CH_STAR) mode_in = MODE_BSTAR;
            MODE_BSTAR: begin
               if (ch == CH_SLASH) begin
                  mode_in = MODE_IDLE;
               end else if (ch != CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end
            end
            default:     mode_in = b_mode;
         endcase
      end
   end

   // Datapath and emitted tokens. The first slot flushes the pending token,
   // the second carries a token begun by this byte or the end-of-file marker.
   always_comb begin
      pos_in    = pos_inc;
      start_in  = start_ff;
      len_in    = len_ff;
      acc_in    = acc_ff;
      use_begin = 1'b0;
      a_valid   = 1'b0;
      a_type    = TOK_DELIM;
      a_start   = start_ff;
      a_len     = len_ff;
      a_val     = '0;
      b_valid   = 1'b0;
      b_type    = TOK_DELIM;
      b_rstart  = pos_ff;
      b_rlen    = POS_BITS'(1);
      if (is_end) begin
         unique case (mode_ff)
            MODE_WORD: begin
               a_valid = 1'b1;
               a_type  = TOK_WORD;
            end
            MODE_NUMBER: begin
               a_valid = 1'b1;
               a_type  = TOK_NUMBER;
               a_val   = acc_ff;
            end
            MODE_STRING: begin
               a_valid = 1'b1;
               a_type  = TOK_ERROR;
            end
            MODE_STRQ: begin
               a_valid = 1'b1;
               a_type  = TOK_STRING;
            end
            MODE_DASH, MODE_SLASH, MODE_GT, MODE_LT, MODE_BANG: begin
               a_valid = 1'b1;
               a_len   = POS_BITS'(1);
            end
            default: ;
         endcase
         b_valid  = 1'b1;
         b_type   = TOK_EOF;
         b_rlen   = '0;
         pos_in   = '0;
         start_in = '0;
         len_in   = '0;
         acc_in   = '0;
      end else begin
         unique case (mode_ff)
            MODE_WORD: begin
               if (is_wordch) begin
                  len_in = sat_add(len_ff, 2'd1);
               end else begin
                  a_valid   = 1'b1;
                  a_type    = TOK_WORD;
                  use_begin = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit) begin
                  acc_in = acc_next;
                  len_in = sat_add(len_ff, 2'd1);
               end else begin
                  a_valid   = 1'b1;
                  a_type    = TOK_NUMBER;
                  a_val     = acc_ff;
                  use_begin = 1'b1;
               end
            end
            MODE_STRING: begin
               if (ch != CH_QUOTE) len_in = sat_add(len_ff, 2'd1);
            end
            MODE_STRQ: begin
               // A doubled quote stays in the content as two bytes.
               if (ch == CH_QUOTE) begin
                  len_in = sat_add(len_ff, 2'd2);
               end else begin
                  a_valid   = 1'b1;
                  a_type    = TOK_STRING;
                  use_begin = 1'b1;
               end
            end
            MODE_DASH: begin
               if (ch != CH_DASH) begin
                  a_valid   = 1'b1;
                  a_len     = POS_BITS'(1);
                  use_begin = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (ch != CH_STAR) begin
                  a_valid   = 1'b1;
                  a_len     = POS_BITS'(1);
                  use_begin = 1'b1;
               end
            end
            MODE_GT, MODE_LT, MODE_BANG: begin
               a_valid = 1'b1;
               if (pair_hit) begin
                  a_len = POS_BITS'(2);
               end else begin
                  a_len     = POS_BITS'(1);
                  use_begin = 1'b1;
               end
            end
            MODE_LINE, MODE_BLOCK, MODE_BSTAR: ;
            default: use_begin = 1'b1;
         endcase
         if (use_begin) begin
            start_in = b_start;
            len_in   = b_len;
            acc_in   = b_acc;
            b_valid  = b_delim;
         end
      end
   end

   always_comb begin
      res_a.token_type   = a_type;
      res_a.start_offset = to_out_pos(a_start);
      res_a.token_length = to_out_pos(a_len);
      res_a.number_value = to_out_val(a_val);
      res_a.last         = !b_valid;
      res_b.token_type   = b_type;
      res_b.start_offset = to_out_pos(b_rstart);
      res_b.token_length = to_out_pos(b_rlen);
      res_b.number_value = '0;
      res_b.last         = 1'b1;
      result1 = res_b;
      if (a_valid) begin
         result0 = res_a;
      end else begin
         result0 = res_b;
      end
      result_count = {1'b0, a_valid} + {1'b0, b_valid};
   end

endmodule

`default_nettype wire

[rtl/sqllex_rsp_queue.sv]
// Four-entry result queue that takes up to two tokens per cycle.
`default_nettype none

module sqllex_rsp_queue
   import sqllex_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [1:0]    push_count,
   input  wire result_type    push_data0,
   input  wire result_type    push_data1,
   input  wire logic          pop,
   output logic               has_room,
   output logic               head_valid,
   output result_type         head_data
);

   localparam int DEPTH    = 4;
   localparam int IDX_BITS = $clog2(DEPTH);

   result_type            entry_ff [DEPTH];
   logic [IDX_BITS-1:0]   wr_ff, wr_in, rd_ff, rd_in, wr_next_idx;
   logic [IDX_BITS:0]     count_ff, count_in;
   logic                  do_pop;

   assign do_pop      = pop && head_valid;
   assign head_valid  = (count_ff != '0);
   assign head_data   = entry_ff[rd_ff];
   // Room for the worst case of two tokens from one byte.
   assign has_room    = (count_ff <= (IDX_BITS+1)'(DEPTH - 2));
   assign wr_next_idx = wr_ff + IDX_BITS'(1);
   assign wr_in       = wr_ff + IDX_BITS'(push_count);
   assign rd_in       = rd_ff + IDX_BITS'(do_pop);
   assign count_in    = count_ff + (IDX_BITS+1)'(push_count) - (IDX_BITS+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) entry_ff[wr_ff] <= push_data0;
      if (push_count == 2'd2) entry_ff[wr_next_idx] <= push_data1;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (IDX_BITS+1)'(DEPTH))
      else $error("result queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |-> ((IDX_BITS+2)'(count_ff) + (IDX_BITS+2)'(push_count)
                                <= (IDX_BITS+2)'(DEPTH)))
      else $error("result queue written while full");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the streaming SQL token lexer core.
`timescale 1ns / 100ps

module tb;
   import sqllex_pkg::*;

   localparam int IDLE_PCT    = 29;
   localparam int HOLD_CYCLES = 80;
   localparam int STALL_LIMIT = 2000;

   // Scoreboard: predicts the tokens of every accepted byte and checks each token seen.
   class lex_scoreboard;
      result_type  expected_tokens [$];
      int          errors      = 0;
      int          tokens_seen = 0;
      mode_type    mode;
      logic [15:0] pos;
      logic [15:0] tstart;
      logic [15:0] tlen;
      logic [31:0] acc;

      function new();
         restart();
      endfunction

      function void restart();
         mode   = MODE_IDLE;
         pos    = '0;
         tstart = '0;
         tlen   = '0;
         acc    = '0;
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 40) $display("MISMATCH: %s", msg);
      endfunction

      function logic [15:0] bump(logic [15:0] x, int k);
         int s;
         s = int'(x) + k;
         return (s > 16'hFFFF) ? 16'hFFFF : 16'(s);
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      function bit is_letter(logic [7:0] c);
         return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
      endfunction

      function void push_token(tok_type_type t, logic [15:0] so, logic [15:0] len,
                               logic [31:0] val);
         result_type r;
         r.token_type   = t;
         r.start_offset = so;
         r.token_length = len;
         r.number_value = val;
         r.last         = 1'b0;
         expected_tokens.push_back(r);
      endfunction

      function void open_token(logic [7:0] c, logic [15:0] p);
         mode   = MODE_IDLE;
         tstart = p;
         tlen   = '0;
         acc    = '0;
         if (is_blank(c)) return;
         if (is_letter(c) || c == CH_UNDER) begin
            mode = MODE_WORD;
            tlen = 16'd1;
         end else if (is_digit(c)) begin
            mode = MODE_NUMBER;
            tlen = 16'd1;
            acc  = 32'(c - CH_ZERO);
         end else if (c == CH_QUOTE) begin
            mode   = MODE_STRING;
            tstart = bump(p, 1);
         end else if (c == CH_DASH) begin
            mode = MODE_DASH;
         end else if (c == CH_SLASH) begin
            mode = MODE_SLASH;
         end else if (c == CH_GT) begin
            mode = MODE_GT;
         end else if (c == CH_LT) begin
            mode = MODE_LT;
         end else if (c == CH_BANG) begin
            mode = MODE_BANG;
         end else begin
            push_token(TOK_DELIM, p, 16'd1, '0);
         end
      endfunction

      function void note_byte(logic [7:0] c, logic at_end);
         logic [15:0] p;
         int          first;
         p     = pos;
         first = expected_tokens.size();
         if (at_end || c == CH_NUL) begin
            case (mode)
               MODE_WORD:   push_token(TOK_WORD, tstart, tlen, '0);
               MODE_NUMBER: push_token(TOK_NUMBER, tstart, tlen, acc);
               MODE_STRING: push_token(TOK_ERROR, tstart, tlen, '0);
               MODE_STRQ:   push_token(TOK_STRING, tstart, tlen, '0);
               MODE_DASH, MODE_SLASH, MODE_GT, MODE_LT, MODE_BANG:
                  push_token(TOK_DELIM, tstart, 16'd1, '0);
               default: ;
            endcase
            push_token(TOK_EOF, p, '0, '0);
            restart();
         end else begin
            case (mode)
               MODE_WORD: begin
                  if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
                     tlen = bump(tlen, 1);
                  end else begin
                     push_token(TOK_WORD, tstart, tlen, '0);
                     open_token(c, p);
                  end
               end
               MODE_NUMBER: begin
                  if (is_digit(c)) begin
                     acc  = acc * 32'd10 + 32'(c - CH_ZERO);
                     tlen = bump(tlen, 1);
                  end else begin
                     push_token(TOK_NUMBER, tstart, tlen, acc);
                     open_token(c, p);
                  end
               end
               MODE_STRING: begin
                  if (c == CH_QUOTE) mode = MODE_STRQ;
                  else tlen = bump(tlen, 1);
               end
               MODE_STRQ: begin
                  // A doubled quote is an escape and stays in the content.
                  if (c == CH_QUOTE) begin
                     tlen = bump(tlen, 2);
                     mode = MODE_STRING;
                  end else begin
                     push_token(TOK_STRING, tstart, tlen, '0);
                     open_token(c, p);
                  end
               end
               MODE_DASH: begin
                  if (c == CH_DASH) begin
                     mode = MODE_LINE;
                  end else begin
                     push_token(TOK_DELIM, tstart, 16'd1, '0);
                     open_token(c, p);
                  end
               end
               MODE_SLASH: begin
                  if (c == CH_STAR) begin
                     mode = MODE_BLOCK;
                  end else begin
                     push_token(TOK_DELIM, tstart, 16'd1, '0);
                     open_token(c, p);
                  end
               end
               MODE_GT, MODE_LT, MODE_BANG: begin
                  if (c == CH_EQUAL || (mode == MODE_LT && c == CH_GT)) begin
                     push_token(TOK_DELIM, tstart, 16'd2, '0);
                     mode = MODE_IDLE;
                  end else begin
                     push_token(TOK_DELIM, tstart, 16'd1, '0);
                     open_token(c, p);
                  end
               end
               MODE_LINE: begin
                  if (c == CH_NEWLINE) mode = MODE_IDLE;
               end
               MODE_BLOCK: begin
                  if (c == CH_STAR) mode = MODE_BSTAR;
               end
               MODE_BSTAR: begin
                  if (c == CH_SLASH) mode = MODE_IDLE;
                  else if (c != CH_STAR) mode = MODE_BLOCK;
               end
               default: open_token(c, p);
            endcase
            pos = bump(p, 1);
         end
         if (expected_tokens.size() > first)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
      endfunction

      function void check_token(logic [2:0] t, logic [15:0] so, logic [15:0] len,
                                logic [31:0] val, logic lst);
         result_type want;
         tokens_seen++;
         if (expected_tokens.size() == 0) begin
            report($sformatf("unexpected token type %0d offset %0d", t, so));
            return;
         end
         want = expected_tokens.pop_front();
         if (t !== want.token_type)
            report($sformatf("token_type %0d, want %0d", t, want.token_type));
         if (so !== want.start_offset)
            report($sformatf("start_offset %0d, want %0d", so, want.start_offset));
         if (len !== want.token_length)
            report($sformatf("token_length %0d, want %0d", len, want.token_length));
         if (val !== want.number_value)
            report($sformatf("number_value %0d, want %0d", val, want.number_value));
         if (lst !== want.last)
            report($sformatf("last %0b, want %0b", lst, want.last));
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_ch = 8'd0;
   logic                      req_at_end = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [TYPE_BITS-1:0]      rsp_token_type;
   logic [OUT_POS_BITS-1:0]   rsp_start_offset;
   logic [OUT_POS_BITS-1:0]   rsp_token_length;
   logic [OUT_VALUE_BITS-1:0] rsp_number_value;
   logic                      rsp_last;

   lex_scoreboard sb;
   bit            steady = 1'b0;
   int            fed    = 0;
   string         delim_forms [$] = '{">=", "<=", "!=", "<>", ">", "<", "!", "-", "/",
                                     "(", ")", ",", ";", "*", "=", "+", ".", "<<", ">>"};

   sql_token_lexer_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ch           (req_ch),
      .req_at_end       (req_at_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_type   (rsp_token_type),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_number_value (rsp_number_value),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] word_start();
      if ($urandom_range(9) == 0) return CH_UNDER;
      return ($urandom_range(1) ? CH_LOW_A : CH_UP_A) + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] word_char();
      case ($urandom_range(3))
         0:       return CH_ZERO + 8'($urandom_range(9));
         1:       return CH_UNDER;
         default: return CH_LOW_A + 8'($urandom_range(25));
      endcase
   endfunction

   task automatic send_item(input logic [7:0] c, input logic at_end);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_ch     <= c;
      req_at_end <= at_end;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(c, at_end);
      fed++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_tokens.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_piece();
      int         kind;
      int         n;
      logic [7:0] c;
      kind = $urandom_range(19);
      if (kind < 4) begin
         send_item(word_start(), 1'b0);
         repeat ($urandom_range(6)) send_item(word_char(), 1'b0);
      end else if (kind < 7) begin
         // Long digit runs wrap the value.
         n = ($urandom_range(4) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
         repeat (n) send_item(CH_ZERO + 8'($urandom_range(9)), 1'b0);
      end else if (kind < 10) begin
         send_item(CH_QUOTE, 1'b0);
         repeat ($urandom_range(5)) begin
            if ($urandom_range(4) == 0) begin
               send_text("''");
            end else begin
               c = 8'($urandom_range(1, 255));
               send_item((c == CH_QUOTE) ? CH_UNDER : c, 1'b0);
            end
         end
         if ($urandom_range(5) != 0) send_item(CH_QUOTE, 1'b0);
      end else if (kind < 14) begin
         send_text(delim_forms[$urandom_range(delim_forms.size() - 1)]);
      end else if (kind < 16) begin
         send_item($urandom_range(1) ? CH_SPACE : CH_TAB + 8'($urandom_range(4)), 1'b0);
      end else if (kind == 16) begin
         send_text("--");
         repeat ($urandom_range(4)) send_item(8'($urandom_range(1, 255)), 1'b0);
         send_item(CH_NEWLINE, 1'b0);
      end else if (kind == 17) begin
         send_text("/*");
         repeat ($urandom_range(5)) begin
            c = 8'($urandom_range(1, 255));
            send_item(($urandom_range(3) == 0) ? CH_STAR : c, 1'b0);
         end
         send_text($urandom_range(1) ? "*/" : "**/");
      end else begin
         // Raw noise over the whole byte range, a zero byte included.
         send_item(8'($urandom), 1'b0);
      end
   endtask

   task automatic send_random_text();
      repeat ($urandom_range(1, 8)) send_random_piece();
      if ($urandom_range(3) == 0) send_item(CH_NUL, 1'b0);
      else send_item(8'($urandom), 1'b1);
   endtask

   // Result side: random back-pressure plus one long hold-off that fills the queue.
   initial begin : rsp_side
      int hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_token(rsp_token_type, rsp_start_offset, rsp_token_length,
                           rsp_number_value, rsp_last);
         if (!held && sb.tokens_seen >= 40) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin : watchdog
      int stuck;
      stuck = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck = 0;
         else stuck++;
         if (stuck >= STALL_LIMIT) begin
            $display("sql_token_lexer_core verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Two-byte delimiters, an escaped quote, and end flagged with a high byte.
      send_text("a1>='x''y'<>");
      send_item(8'hFF, 1'b1);
      // High byte as a delimiter, held delimiters, and an unclosed block comment
      // ended by a zero byte.
      send_item(8'hFF, 1'b0);
      send_text("!-/*");
      send_item(CH_NUL, 1'b0);
      // Unclosed string at the end of the text.
      send_text("'ab");
      send_item(CH_NUL, 1'b1);
      wait_drained();

      fed = 0;
      while (fed < 230) send_random_text();
      wait_drained();

      // A stretch of text with no idling on either side.
      steady = 1'b1;
      fed = 0;
      while (fed < 60) send_random_text();
      steady = 1'b0;

      fed = 0;
      while (fed < 200) send_random_text();

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.expected_tokens.size() != 0)
         sb.report($sformatf("%0d tokens never arrived", sb.expected_tokens.size()));
      if (sb.errors == 0) begin
         $display("sql_token_lexer_core verification clean");
      end else begin
         $display("sql_token_lexer_core verification failed");
      end
      $finish;
   end

endmodule
